// ===== hw/rtl/mni_pkg.sv =====
// ----------------------------------------------------------------------------
// mni_pkg
// Shared types, constants and the sequencer program of the modal Newmark
// integrator.
// ----------------------------------------------------------------------------
package mni_pkg;

  localparam int unsigned MaxModesDef  = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned ValW         = 32;
  localparam int unsigned ModeW        = 4;
  localparam int unsigned ErrW         = 2;
  localparam int unsigned StepTimeW    = 31;
  localparam logic [StepTimeW-1:0] StepTimeRst = 31'd655;
  localparam int unsigned UpcW         = 6;
  localparam logic [UpcW-1:0] UcodeSetup = 6'd0;
  localparam logic [UpcW-1:0] UcodeStep  = 6'd7;

  typedef enum logic [ErrW-1:0] {
    ERR_OK   = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_SAT  = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    OP_END, OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_SCL2, OP_SCL4, OP_CLMP, OP_CHKZ
  } alu_op_e;

  typedef enum logic [3:0] {
    R_M, R_K, R_C, R_U, R_V, R_A, R_P, R_PO, R_DT, R_T0, R_T1, R_T2, R_T3, R_T4
  } reg_sel_e;

  typedef struct packed {
    alu_op_e  op;
    reg_sel_e a;
    reg_sel_e b;
    reg_sel_e dst;
  } ucmd_t;

  typedef struct packed {
    logic  load_in;
    logic  clear_oor;
    logic  load_mem;
    logic  go;
    ucmd_t ucmd;
    logic  mem_we;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic zero;
  } dp_stat_t;

  function automatic ucmd_t uc(alu_op_e op, reg_sel_e a, reg_sel_e b, reg_sel_e dst);
    ucmd_t c;
    c.op  = op;
    c.a   = a;
    c.b   = b;
    c.dst = dst;
    return c;
  endfunction

  // Set-up program first, then the time step program.
  function automatic ucmd_t ucode(logic [UpcW-1:0] pc);
    ucmd_t c;
    case (pc)
      6'd0:  c = uc(OP_MUL,  R_C,  R_V,  R_T0);
      6'd1:  c = uc(OP_SUB,  R_P,  R_T0, R_T0);
      6'd2:  c = uc(OP_MUL,  R_K,  R_U,  R_T1);
      6'd3:  c = uc(OP_SUB,  R_T0, R_T1, R_T0);
      6'd4:  c = uc(OP_DIV,  R_T0, R_M,  R_A);
      6'd5:  c = uc(OP_CLMP, R_A,  R_A,  R_A);
      6'd6:  c = uc(OP_END,  R_M,  R_M,  R_M);
      6'd7:  c = uc(OP_MUL,  R_DT, R_DT, R_T0);
      6'd8:  c = uc(OP_MUL,  R_K,  R_T0, R_T1);
      6'd9:  c = uc(OP_MUL,  R_C,  R_DT, R_T2);
      6'd10: c = uc(OP_SCL2, R_T2, R_T2, R_T2);
      6'd11: c = uc(OP_ADD,  R_T1, R_T2, R_T1);
      6'd12: c = uc(OP_SCL4, R_M,  R_M,  R_T2);
      6'd13: c = uc(OP_ADD,  R_T1, R_T2, R_T1);
      6'd14: c = uc(OP_CHKZ, R_DT, R_T1, R_T1);
      6'd15: c = uc(OP_SUB,  R_P,  R_PO, R_T2);
      6'd16: c = uc(OP_MUL,  R_C,  R_V,  R_T3);
      6'd17: c = uc(OP_SCL2, R_T3, R_T3, R_T3);
      6'd18: c = uc(OP_MUL,  R_M,  R_A,  R_T4);
      6'd19: c = uc(OP_SCL2, R_T4, R_T4, R_T4);
      6'd20: c = uc(OP_ADD,  R_T3, R_T4, R_T3);
      6'd21: c = uc(OP_ADD,  R_T2, R_T3, R_T2);
      6'd22: c = uc(OP_MUL,  R_T0, R_T2, R_T2);
      6'd23: c = uc(OP_MUL,  R_M,  R_DT, R_T3);
      6'd24: c = uc(OP_MUL,  R_T3, R_V,  R_T3);
      6'd25: c = uc(OP_SCL4, R_T3, R_T3, R_T3);
      6'd26: c = uc(OP_ADD,  R_T2, R_T3, R_T2);
      6'd27: c = uc(OP_DIV,  R_T2, R_T1, R_T2);
      6'd28: c = uc(OP_DIV,  R_T2, R_DT, R_T3);
      6'd29: c = uc(OP_SCL2, R_T3, R_T3, R_T3);
      6'd30: c = uc(OP_SCL2, R_V,  R_V,  R_T4);
      6'd31: c = uc(OP_SUB,  R_T3, R_T4, R_T3);
      6'd32: c = uc(OP_DIV,  R_T3, R_DT, R_T4);
      6'd33: c = uc(OP_SCL2, R_T4, R_T4, R_T4);
      6'd34: c = uc(OP_SCL2, R_A,  R_A,  R_T0);
      6'd35: c = uc(OP_SUB,  R_T4, R_T0, R_T4);
      6'd36: c = uc(OP_ADD,  R_U,  R_T2, R_U);
      6'd37: c = uc(OP_CLMP, R_U,  R_U,  R_U);
      6'd38: c = uc(OP_ADD,  R_V,  R_T3, R_V);
      6'd39: c = uc(OP_CLMP, R_V,  R_V,  R_V);
      6'd40: c = uc(OP_ADD,  R_A,  R_T4, R_A);
      6'd41: c = uc(OP_CLMP, R_A,  R_A,  R_A);
      default: c = uc(OP_END, R_M, R_M, R_M);
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/mni_ram.sv =====
// ----------------------------------------------------------------------------
// mni_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mni_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/mni_ctrl.sv =====
// ----------------------------------------------------------------------------
// mni_ctrl
// Controller: accepts items and steps the datapath through its program.
// ----------------------------------------------------------------------------
module mni_ctrl #(
  parameter int unsigned MaxModes = mni_pkg::MaxModesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      op_i,
  input  logic [mni_pkg::ModeW-1:0] mode_i,
  input  mni_pkg::dp_stat_t         stat_i,
  output mni_pkg::dp_cmd_t          cmd_o,
  output logic                      busy_o,
  output logic                      done_o
);
  import mni_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ISSUE = 6'b000100,
    S_WAIT  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } ctrl_state_e;

  ctrl_state_e     state_q, state_d;
  logic [UpcW-1:0] pc_q, pc_d;
  logic            step_q, step_d;
  logic            oor;
  ucmd_t           cur;

  assign oor = (32'(mode_i) >= MaxModes);
  assign cur = ucode(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.ucmd = cur;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          step_d = op_i;
          if (oor) begin
            cmd_o.clear_oor = 1'b1;
            state_d = S_DONE;
          end else if (op_i) begin
            pc_d = UcodeStep;
            state_d = S_LOAD;
          end else begin
            pc_d = UcodeSetup;
            state_d = S_ISSUE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_mem = 1'b1;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (cur.op == OP_END) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.go = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!stat_i.unit_busy) begin
          if (stat_i.zero && step_q) begin
            state_d = S_DONE;
          end else begin
            pc_d = pc_q + 1'b1;
            state_d = S_ISSUE;
          end
        end
      end
      S_WRITE: begin
        cmd_o.mem_we = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      step_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== hw/rtl/mni_datapath.sv =====
// ----------------------------------------------------------------------------
// mni_datapath
// Operand registers, saturating ALU, sequential multiplier and divider, and
// the per-mode state RAM.
// ----------------------------------------------------------------------------
module mni_datapath #(
  parameter int unsigned MaxModes = mni_pkg::MaxModesDef,
  parameter int unsigned FracBits = mni_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mni_pkg::dp_cmd_t              cmd_i,
  output mni_pkg::dp_stat_t             stat_o,
  input  logic                          step_time_we_i,
  input  logic [mni_pkg::StepTimeW-1:0] step_time_i,
  input  logic [mni_pkg::ModeW-1:0]     mode_i,
  input  logic signed [31:0]            mass_i,
  input  logic signed [31:0]            stiffness_i,
  input  logic signed [31:0]            damping_i,
  input  logic signed [31:0]            load_i,
  input  logic signed [31:0]            init_disp_i,
  input  logic signed [31:0]            init_vel_i,
  output logic [mni_pkg::ModeW-1:0]     mode_out_o,
  output logic signed [31:0]            displacement_o,
  output logic signed [31:0]            velocity_o,
  output logic signed [31:0]            acceleration_o,
  output logic [mni_pkg::ErrW-1:0]      error_o
);
  import mni_pkg::*;

  localparam int unsigned SW    = 63 - FracBits;
  localparam int unsigned MW    = SW - 1;
  localparam int unsigned CW    = 16;
  localparam int unsigned NCh   = (MW + CW - 1) / CW;
  localparam int unsigned PW    = NCh * CW;
  localparam int unsigned AccW  = 2 * MW;
  localparam int unsigned NumW  = MW + FracBits;
  localparam int unsigned CntW  = $clog2(NumW + 1);
  localparam int unsigned AddrW = (MaxModes > 1) ? $clog2(MaxModes) : 1;
  localparam int unsigned WordW = 7 * ValW;

  localparam logic [MW-1:0]         WMaxM  = {MW{1'b1}};
  localparam logic [AccW-1:0]       WMaxA  = AccW'(WMaxM);
  localparam logic [NumW-1:0]       WMaxN  = NumW'(WMaxM);
  localparam logic signed [SW+1:0]  WMaxX  = (SW + 2)'({1'b0, WMaxM});
  localparam logic signed [SW+1:0]  Max32X = (SW + 2)'(64'sd2147483647);
  localparam logic signed [SW+1:0]  Min32X = (SW + 2)'(-64'sd2147483648);

  typedef logic signed [SW-1:0] wide_t;

  function automatic wide_t sx(logic [31:0] x);
    return {{(SW - 32){x[31]}}, x};
  endfunction

  function automatic logic [MW-1:0] mag(wide_t x);
    wide_t n;
    n = x[SW-1] ? -x : x;
    return n[MW-1:0];
  endfunction

  // Operand and temporary registers
  wide_t m_q, k_q, c_q, u_q, v_q, a_q, p_q, po_q, t0_q, t1_q, t2_q, t3_q, t4_q;
  logic [ModeW-1:0]     mode_q;
  logic [StepTimeW-1:0] step_time_q;
  logic                 sat_q, zero_q;

  // Multiply and divide unit
  logic             mul_q, div_q, fin_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  reg_sel_e         dst_q;
  logic [MW-1:0]    mua_q, den_q, rem_q;
  logic [PW-1:0]    mub_q;
  logic [AccW-1:0]  acc_q;
  logic [NumW-1:0]  num_q;

  wide_t opa, opb, dt_w;
  ucmd_t uop;

  assign uop  = cmd_i.ucmd;
  assign dt_w = wide_t'({1'b0, step_time_q});

  function automatic wide_t rd(reg_sel_e s, wide_t m, wide_t k, wide_t c, wide_t u,
                               wide_t v, wide_t a, wide_t p, wide_t po, wide_t dt,
                               wide_t t0, wide_t t1, wide_t t2, wide_t t3, wide_t t4);
    wide_t r;
    case (s)
      R_M:  r = m;
      R_K:  r = k;
      R_C:  r = c;
      R_U:  r = u;
      R_V:  r = v;
      R_A:  r = a;
      R_P:  r = p;
      R_PO: r = po;
      R_DT: r = dt;
      R_T0: r = t0;
      R_T1: r = t1;
      R_T2: r = t2;
      R_T3: r = t3;
      R_T4: r = t4;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign opa = rd(uop.a, m_q, k_q, c_q, u_q, v_q, a_q, p_q, po_q, dt_w,
                  t0_q, t1_q, t2_q, t3_q, t4_q);
  assign opb = rd(uop.b, m_q, k_q, c_q, u_q, v_q, a_q, p_q, po_q, dt_w,
                  t0_q, t1_q, t2_q, t3_q, t4_q);

  // Combinational saturating ALU
  logic signed [SW+1:0] ext_a, ext_b, pre, hi, lo;
  wide_t                alu_res;
  logic                 alu_sat, alu_op;

  always_comb begin
    ext_a = (SW + 2)'(opa);
    ext_b = (SW + 2)'(opb);
    alu_op = 1'b1;
    case (uop.op)
      OP_ADD:  pre = ext_a + ext_b;
      OP_SUB:  pre = ext_a - ext_b;
      OP_SCL2: pre = ext_a <<< 1;
      OP_SCL4: pre = ext_a <<< 2;
      OP_CLMP: pre = ext_a;
      default: begin
        pre = ext_a;
        alu_op = 1'b0;
      end
    endcase
    if (uop.op == OP_CLMP) begin
      hi = Max32X;
      lo = Min32X;
    end else begin
      hi = WMaxX;
      lo = -WMaxX;
    end
    alu_sat = 1'b0;
    if (pre > hi) begin
      alu_sat = 1'b1;
      pre = hi;
    end else if (pre < lo) begin
      alu_sat = 1'b1;
      pre = lo;
    end
    alu_res = SW'(pre);
  end

  // Finalize of the multiplier and divider
  logic [AccW-1:0] mres;
  logic [MW-1:0]   fmag;
  logic            fovf;
  wide_t           fres;

  always_comb begin
    mres = acc_q >> FracBits;
    if (mul_q) begin
      fovf = (mres > WMaxA);
      fmag = fovf ? WMaxM : mres[MW-1:0];
    end else begin
      fovf = (num_q > WMaxN);
      fmag = fovf ? WMaxM : num_q[MW-1:0];
    end
    fres = neg_q ? -wide_t'({1'b0, fmag}) : wide_t'({1'b0, fmag});
  end

  // Iteration steps
  logic [MW+CW-1:0] pp;
  logic [MW:0]      trial;
  logic             ge;

  assign pp    = mua_q * mub_q[PW-1 -: CW];
  assign trial = {rem_q, num_q[NumW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  // Register write port
  logic     wr_en, div0;
  reg_sel_e wr_sel;
  wide_t    wr_val;

  assign div0 = cmd_i.go && (uop.op == OP_DIV) && (opb == '0);

  always_comb begin
    wr_en  = 1'b0;
    wr_sel = uop.dst;
    wr_val = alu_res;
    if (fin_q) begin
      wr_en  = 1'b1;
      wr_sel = dst_q;
      wr_val = fres;
    end else if (cmd_i.go && alu_op) begin
      wr_en = 1'b1;
    end else if (div0) begin
      wr_en  = 1'b1;
      wr_val = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_time_q <= StepTimeRst;
      sat_q  <= 1'b0;
      zero_q <= 1'b0;
      mul_q  <= 1'b0;
      div_q  <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (step_time_we_i) begin
        step_time_q <= step_time_i;
      end
      fin_q <= 1'b0;
      if (cmd_i.load_in) begin
        sat_q  <= 1'b0;
        zero_q <= cmd_i.clear_oor;
      end else if (cmd_i.go) begin
        if (alu_op && alu_sat) begin
          sat_q <= 1'b1;
        end
        if (uop.op == OP_CHKZ && (opa == '0 || opb == '0)) begin
          zero_q <= 1'b1;
        end
        if (div0) begin
          zero_q <= 1'b1;
        end
        if (uop.op == OP_MUL) begin
          mul_q <= 1'b1;
          cnt_q <= CntW'(NCh);
        end
        if (uop.op == OP_DIV && !div0) begin
          div_q <= 1'b1;
          cnt_q <= CntW'(NumW);
        end
      end else if (mul_q || div_q) begin
        if (fin_q) begin
          mul_q <= 1'b0;
          div_q <= 1'b0;
          if (fovf) begin
            sat_q <= 1'b1;
          end
        end else begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            fin_q <= 1'b1;
          end
        end
      end
    end
  end

  // Payload
  logic [WordW-1:0] ram_rdata;

  mni_ram #(.Width(WordW), .Depth(MaxModes)) u_mni_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .waddr_i (AddrW'(mode_q)),
    .wdata_i ({m_q[31:0], k_q[31:0], c_q[31:0], u_q[31:0], v_q[31:0], a_q[31:0],
               p_q[31:0]}),
    .raddr_i (AddrW'(mode_i)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      m_q <= sx(mass_i);
      k_q <= sx(stiffness_i);
      c_q <= sx(damping_i);
      u_q <= cmd_i.clear_oor ? '0 : sx(init_disp_i);
      v_q <= cmd_i.clear_oor ? '0 : sx(init_vel_i);
      a_q <= '0;
      p_q <= sx(load_i);
    end else if (cmd_i.load_mem) begin
      m_q  <= sx(ram_rdata[6*ValW +: ValW]);
      k_q  <= sx(ram_rdata[5*ValW +: ValW]);
      c_q  <= sx(ram_rdata[4*ValW +: ValW]);
      u_q  <= sx(ram_rdata[3*ValW +: ValW]);
      v_q  <= sx(ram_rdata[2*ValW +: ValW]);
      a_q  <= sx(ram_rdata[1*ValW +: ValW]);
      po_q <= sx(ram_rdata[0 +: ValW]);
    end else if (wr_en) begin
      case (wr_sel)
        R_M:  m_q  <= wr_val;
        R_K:  k_q  <= wr_val;
        R_C:  c_q  <= wr_val;
        R_U:  u_q  <= wr_val;
        R_V:  v_q  <= wr_val;
        R_A:  a_q  <= wr_val;
        R_P:  p_q  <= wr_val;
        R_PO: po_q <= wr_val;
        R_T0: t0_q <= wr_val;
        R_T1: t1_q <= wr_val;
        R_T2: t2_q <= wr_val;
        R_T3: t3_q <= wr_val;
        R_T4: t4_q <= wr_val;
        default: ;
      endcase
    end

    if (cmd_i.go) begin
      dst_q <= uop.dst;
      neg_q <= opa[SW-1] ^ opb[SW-1];
      mua_q <= mag(opa);
      mub_q <= PW'(mag(opb));
      acc_q <= '0;
      den_q <= mag(opb);
      rem_q <= '0;
      num_q <= {mag(opa), {FracBits{1'b0}}};
    end else if (!fin_q) begin
      if (mul_q) begin
        acc_q <= (acc_q << CW) + AccW'(pp);
        mub_q <= mub_q << CW;
      end
      if (div_q) begin
        rem_q <= ge ? MW'(trial - {1'b0, den_q}) : trial[MW-1:0];
        num_q <= {num_q[NumW-2:0], ge};
      end
    end
  end

  assign stat_o.unit_busy = mul_q | div_q;
  assign stat_o.zero      = zero_q;

  assign mode_out_o     = mode_q;
  assign displacement_o = u_q[31:0];
  assign velocity_o     = v_q[31:0];
  assign acceleration_o = a_q[31:0];
  assign error_o        = zero_q ? ERR_ZERO : (sat_q ? ERR_SAT : ERR_OK);

endmodule

// ===== hw/rtl/modal_newmark_integrator.sv =====
// ----------------------------------------------------------------------------
// modal_newmark_integrator
// Per-mode incremental Newmark integrator (average acceleration) in fixed
// point, built from a sequencing controller and a shared datapath.
// A time step finishes early when the step time or the effective stiffness
// is zero; a new item can be accepted in the cycle after done_o.
// One item at a time; busy_o is high from start to the done_o strobe.
// Reset clears the controller and sets step_time to its reset value;
// the mode table is undefined until a set-up item writes it.
// ----------------------------------------------------------------------------
module modal_newmark_integrator #(
  parameter int unsigned MAX_MODES = mni_pkg::MaxModesDef,
  parameter int unsigned FRAC_BITS = mni_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          step_time_we_i,
  input  logic [mni_pkg::StepTimeW-1:0] step_time_i,
  input  logic                          op_i,
  input  logic [mni_pkg::ModeW-1:0]     mode_i,
  input  logic signed [31:0]            mass_i,
  input  logic signed [31:0]            stiffness_i,
  input  logic signed [31:0]            damping_i,
  input  logic signed [31:0]            load_i,
  input  logic signed [31:0]            init_disp_i,
  input  logic signed [31:0]            init_vel_i,
  output logic                          done_o,
  output logic [mni_pkg::ModeW-1:0]     mode_out_o,
  output logic signed [31:0]            displacement_o,
  output logic signed [31:0]            velocity_o,
  output logic signed [31:0]            acceleration_o,
  output logic [mni_pkg::ErrW-1:0]      error_o
);
  import mni_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mni_ctrl #(.MaxModes(MAX_MODES)) u_mni_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (op_i),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  mni_datapath #(.MaxModes(MAX_MODES), .FracBits(FRAC_BITS)) u_mni_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .step_time_we_i (step_time_we_i),
    .step_time_i    (step_time_i),
    .mode_i         (mode_i),
    .mass_i         (mass_i),
    .stiffness_i    (stiffness_i),
    .damping_i      (damping_i),
    .load_i         (load_i),
    .init_disp_i    (init_disp_i),
    .init_vel_i     (init_vel_i),
    .mode_out_o     (mode_out_o),
    .displacement_o (displacement_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .error_o        (error_o)
  );

endmodule

// ===== hw/rtl/mni_checker.sv =====
// ----------------------------------------------------------------------------
// mni_checker
// Port-level checks of the integrator's transfer sequencing.
// ----------------------------------------------------------------------------
module mni_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [mni_pkg::ErrW-1:0]  error_o
);
  import mni_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe while idle");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy held after the result transfer");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (error_o == ERR_OK || error_o == ERR_ZERO || error_o == ERR_SAT))
    else $error("undefined error code");

endmodule

bind modal_newmark_integrator mni_checker u_mni_checker (.*);

// ===== bench/tb_modal_newmark_integrator.sv =====
// ----------------------------------------------------------------------------
// tb_modal_newmark_integrator
// Self-checking bench for the modal Newmark integrator. A directed table of
// set-up and time step items comes first, then random traffic in bursts under
// several step time settings. Every result transfer is checked field by field
// against a bit-accurate fixed-point predictor or a directed row's own values.
// ----------------------------------------------------------------------------
module tb_modal_newmark_integrator;
  import mni_pkg::*;

  localparam longint WideMax = (64'sd1 <<< 46) - 1;
  localparam bit     OpSetup = 1'b0;
  localparam bit     OpStep  = 1'b1;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic signed [31:0] u, v, a;
    err_e              err;
  } result_t;

  typedef struct {
    bit               op;
    logic [ModeW-1:0] mode;
    logic signed [31:0] m, k, c, p, u0, v0;
    bit               typed;
    result_t          res;
  } row_t;

  logic clk_i, rst_ni, start_i, busy_o, step_time_we_i;
  logic [StepTimeW-1:0] step_time_i;
  logic op_i;
  logic [ModeW-1:0] mode_i, mode_out_o;
  logic signed [31:0] mass_i, stiffness_i, damping_i, load_i, init_disp_i, init_vel_i;
  logic done_o;
  logic signed [31:0] displacement_o, velocity_o, acceleration_o;
  logic [ErrW-1:0] error_o;

  modal_newmark_integrator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .step_time_we_i(step_time_we_i), .step_time_i(step_time_i),
    .op_i(op_i), .mode_i(mode_i), .mass_i(mass_i), .stiffness_i(stiffness_i),
    .damping_i(damping_i), .load_i(load_i), .init_disp_i(init_disp_i),
    .init_vel_i(init_vel_i), .done_o(done_o), .mode_out_o(mode_out_o),
    .displacement_o(displacement_o), .velocity_o(velocity_o),
    .acceleration_o(acceleration_o), .error_o(error_o)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Predictor state.
  longint mode_mass[16], mode_stiff[16], mode_damp[16];
  longint mode_disp[16], mode_vel[16], mode_accel[16], mode_load[16];
  logic [15:0] mode_ready;
  longint dt_q;
  bit sat_seen;

  result_t expected_results[$];
  int mismatches, results_seen, items_sent, steps_sent;

  function automatic longint clamp_wide(longint x);
    if (x > WideMax) begin sat_seen = 1; return WideMax; end
    if (x < -WideMax) begin sat_seen = 1; return -WideMax; end
    return x;
  endfunction

  function automatic longint clamp_word(longint x);
    if (x > 64'sd2147483647) begin sat_seen = 1; return 64'sd2147483647; end
    if (x < -64'sd2147483648) begin sat_seen = 1; return -64'sd2147483648; end
    return x;
  endfunction

  function automatic longint fx_mul(longint x, longint y);
    logic [127:0] prod;
    logic [63:0] ux, uy, r;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    prod = {64'd0, ux} * {64'd0, uy};
    prod = prod >> 16;
    if (prod > WideMax) begin sat_seen = 1; r = WideMax; end
    else r = prod[63:0];
    return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_div(longint x, longint y);
    logic [63:0] ux, uy, q;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    q = (ux << 16) / uy;
    if (q > WideMax) begin sat_seen = 1; q = WideMax; end
    return ((x < 0) != (y < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t integrate(row_t r);
    result_t e;
    longint m, k, c, u, v, a, num, t2, keff, s, du, dv, da;
    bit zero;
    zero = 0;
    sat_seen = 0;
    e.mode = r.mode;
    if (r.op == OpSetup) begin
      m = r.m; k = r.k; c = r.c; u = r.u0; v = r.v0;
      num = clamp_wide(clamp_wide(r.p - fx_mul(c, v)) - fx_mul(k, u));
      if (m == 0) begin zero = 1; a = 0; end
      else a = clamp_word(fx_div(num, m));
      mode_mass[r.mode] = m; mode_stiff[r.mode] = k; mode_damp[r.mode] = c;
      mode_disp[r.mode] = u; mode_vel[r.mode] = v; mode_accel[r.mode] = a;
      mode_load[r.mode] = r.p;
      mode_ready[r.mode] = 1'b1;
    end else begin
      m = mode_mass[r.mode]; k = mode_stiff[r.mode]; c = mode_damp[r.mode];
      u = mode_disp[r.mode]; v = mode_vel[r.mode]; a = mode_accel[r.mode];
      t2 = fx_mul(dt_q, dt_q);
      keff = clamp_wide(clamp_wide(fx_mul(k, t2) + clamp_wide(fx_mul(c, dt_q) * 2))
                        + clamp_wide(m * 4));
      if (dt_q == 0 || keff == 0) begin
        zero = 1;
      end else begin
        s = clamp_wide(clamp_wide(r.p - mode_load[r.mode]) +
                       clamp_wide(clamp_wide(fx_mul(c, v) * 2) +
                                  clamp_wide(fx_mul(m, a) * 2)));
        num = clamp_wide(fx_mul(t2, s) +
                         clamp_wide(fx_mul(fx_mul(m, dt_q), v) * 4));
        du = fx_div(num, keff);
        dv = clamp_wide(clamp_wide(fx_div(du, dt_q) * 2) - clamp_wide(v * 2));
        da = clamp_wide(clamp_wide(fx_div(dv, dt_q) * 2) - clamp_wide(a * 2));
        u = clamp_word(clamp_wide(u + du));
        v = clamp_word(clamp_wide(v + dv));
        a = clamp_word(clamp_wide(a + da));
        mode_disp[r.mode] = u; mode_vel[r.mode] = v; mode_accel[r.mode] = a;
        mode_load[r.mode] = r.p;
      end
    end
    e.u = u[31:0]; e.v = v[31:0]; e.a = a[31:0];
    e.err = zero ? ERR_ZERO : (sat_seen ? ERR_SAT : ERR_OK);
    return e;
  endfunction

  always @(posedge clk_i) begin
    if (done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer, mode %0d", mode_out_o);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (e.mode !== mode_out_o || e.u !== displacement_o || e.v !== velocity_o ||
            e.a !== acceleration_o || e.err !== error_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mode %0d u %h v %h a %h err %0d, got %0d %h %h %h %0d",
                     e.mode, e.u, e.v, e.a, e.err, mode_out_o, displacement_o,
                     velocity_o, acceleration_o, error_o);
        end
      end
    end
  end

  task automatic send_item(row_t r);
    result_t e;
    @(negedge clk_i);
    op_i = r.op; mode_i = r.mode; mass_i = r.m; stiffness_i = r.k; damping_i = r.c;
    load_i = r.p; init_disp_i = r.u0; init_vel_i = r.v0;
    start_i = 1'b1;
    forever begin
      if (!busy_o) begin
        @(posedge clk_i);
        break;
      end
      @(negedge clk_i);
    end
    e = integrate(r);
    if (r.typed) e = r.res;
    expected_results.push_back(e);
    items_sent++;
    if (r.op == OpStep) steps_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_step_time(logic [StepTimeW-1:0] value);
    drain();
    step_time_we_i = 1'b1;
    step_time_i = value;
    @(negedge clk_i);
    step_time_we_i = 1'b0;
    step_time_i = StepTimeW'($urandom);
    dt_q = value;
  endtask

  function automatic logic signed [31:0] mild(int lo, int hi);
    return $urandom_range(hi - lo) + lo;
  endfunction

  function automatic row_t random_row();
    row_t r;
    bit wild;
    r.typed = 0;
    r.mode = ModeW'($urandom_range(15));
    r.op = (mode_ready[r.mode] && $urandom_range(3) != 0) ? OpStep : OpSetup;
    wild = ($urandom_range(9) == 0);
    if (wild) begin
      r.m = $urandom; r.k = $urandom; r.c = $urandom;
      r.p = $urandom; r.u0 = $urandom; r.v0 = $urandom;
    end else begin
      r.m = ($urandom_range(19) == 0) ? 0 : mild(1, 32'h40000);
      r.k = mild(0, 32'h100000);
      r.c = mild(-32'h800, 32'h4000);
      r.p = mild(-32'h20000, 32'h20000);
      r.u0 = mild(-32'h10000, 32'h10000);
      r.v0 = mild(-32'h10000, 32'h10000);
    end
    return r;
  endfunction

  function automatic row_t mk(bit op, int mode, int m, int k, int c, int p, int u0, int v0);
    row_t r;
    r.op = op; r.mode = ModeW'(mode); r.m = m; r.k = k; r.c = c; r.p = p; r.u0 = u0;
    r.v0 = v0;
    r.typed = 0;
    return r;
  endfunction

  function automatic row_t mkx(row_t r, int u, int v, int a, err_e err);
    r.typed = 1;
    r.res.mode = r.mode; r.res.u = u; r.res.v = v; r.res.a = a; r.res.err = err;
    return r;
  endfunction

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t table_rows[$];
    row_t r;
    int burst, gap;
    logic [StepTimeW-1:0] dt_set[5];

    rst_ni = 1'b0; start_i = 1'b0; step_time_we_i = 1'b0; step_time_i = '0;
    op_i = 1'b0; mode_i = '0; mass_i = '0; stiffness_i = '0; damping_i = '0;
    load_i = '0; init_disp_i = '0; init_vel_i = '0;
    mode_ready = '0; dt_q = StepTimeRst;
    mismatches = 0; results_seen = 0; items_sent = 0; steps_sent = 0;
    for (int i = 0; i < 16; i++) begin
      mode_mass[i] = 0; mode_stiff[i] = 0; mode_damp[i] = 0; mode_disp[i] = 0;
      mode_vel[i] = 0; mode_accel[i] = 0; mode_load[i] = 0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    table_rows.push_back(mkx(mk(OpSetup, 0, 32'h10000, 0, 0, 0, 0, 0), 0, 0, 0, ERR_OK));
    table_rows.push_back(mk(OpStep, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mkx(mk(OpSetup, 1, 0, 0, 0, 3, 5, 7), 5, 7, 0, ERR_ZERO));
    table_rows.push_back(mkx(mk(OpStep, 1, 0, 0, 0, 9, 0, 0), 5, 7, 0, ERR_ZERO));
    table_rows.push_back(mk(OpSetup, 2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    table_rows.push_back(mk(OpSetup, 3, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000));
    table_rows.push_back(mk(OpStep, 2, 0, 0, 0, 32'h80000000, 0, 0));
    table_rows.push_back(mk(OpStep, 3, 0, 0, 0, 32'h7fffffff, 0, 0));
    table_rows.push_back(mk(OpSetup, 4, 32'h10000, 32'h40000, 32'h1000, 0, 32'h10000, 0));
    for (int i = 0; i < 5; i++)
      table_rows.push_back(mk(OpStep, 4, 0, 0, 0, i * 32'h1000, 0, 0));
    table_rows.push_back(mk(OpSetup, 15, 32'h20000, 32'h10000, -32'h800, -32'h10000,
                            -32'h8000, 32'h4000));
    table_rows.push_back(mk(OpStep, 15, 0, 0, 0, 32'h10000, 0, 0));
    table_rows.push_back(mk(OpSetup, 5, -32'h10000, -32'h4000, 0, 32'h10000, 0, 0));
    table_rows.push_back(mk(OpStep, 5, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(OpSetup, 6, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                            32'hffffffff, 32'hffffffff));
    table_rows.push_back(mk(OpStep, 6, 0, 0, 0, 32'hffffffff, 0, 0));
    foreach (table_rows[i]) send_item(table_rows[i]);

    dt_set[0] = 31'd655;
    dt_set[1] = 31'd1;
    dt_set[2] = 31'h7fffffff;
    dt_set[3] = 31'd65536;
    dt_set[4] = StepTimeW'($urandom_range(32'h4000, 1));
    for (int ph = 0; ph < 5; ph++) begin
      write_step_time(dt_set[ph]);
      burst = 0;
      for (int n = 0; n < 280; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(20, 1);
          gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(400);
          @(negedge clk_i);
          start_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst--;
        r = random_row();
        send_item(r);
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d items (%0d time steps), %0d results, five step time settings.",
             items_sent, steps_sent, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
